// File: hdl/srtmrg_pkg.sv
// Shared types, codes and the sequencer microcode for the sort-and-merge block.
package srtmrg_pkg;

   localparam int LIST_LEN_DEF = 8;
   localparam int DATA_W       = 32;
   localparam int SWAP_W       = 7;
   localparam int KIND_W       = 2;
   localparam int PC_W         = 3;

   // result run kinds
   localparam logic [KIND_W-1:0] KIND_A     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_B     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MERGE = 2'd2;

   // list write select
   localparam logic [1:0] WR_NONE = 2'd0;
   localparam logic [1:0] WR_LOAD = 2'd1;
   localparam logic [1:0] WR_CMP  = 2'd2;
   localparam logic [1:0] WR_TAIL = 2'd3;

   // pointer operations
   localparam logic [2:0] PTR_HOLD      = 3'd0;
   localparam logic [2:0] PTR_CLEAR     = 3'd1;
   localparam logic [2:0] PTR_WRAP_BOTH = 3'd2;
   localparam logic [2:0] PTR_WRAP_A    = 3'd3;
   localparam logic [2:0] PTR_WRAP_B    = 3'd4;
   localparam logic [2:0] PTR_MERGE     = 3'd5;

   // emit select
   localparam logic [1:0] EMIT_NONE  = 2'd0;
   localparam logic [1:0] EMIT_A     = 2'd1;
   localparam logic [1:0] EMIT_B     = 2'd2;
   localparam logic [1:0] EMIT_MERGE = 2'd3;

   // jump conditions
   localparam logic [2:0] COND_NEVER      = 3'd0;
   localparam logic [2:0] COND_ALWAYS     = 3'd1;
   localparam logic [2:0] COND_LOAD_DONE  = 3'd2;
   localparam logic [2:0] COND_A_LAST     = 3'd3;
   localparam logic [2:0] COND_B_LAST     = 3'd4;
   localparam logic [2:0] COND_PASS_MORE  = 3'd5;
   localparam logic [2:0] COND_MERGE_LAST = 3'd6;

   // program steps
   localparam logic [PC_W-1:0] STEP_LOAD   = 3'd0;
   localparam logic [PC_W-1:0] STEP_PASS   = 3'd1;
   localparam logic [PC_W-1:0] STEP_CMP    = 3'd2;
   localparam logic [PC_W-1:0] STEP_TAIL   = 3'd3;
   localparam logic [PC_W-1:0] STEP_EMIT_A = 3'd4;
   localparam logic [PC_W-1:0] STEP_EMIT_B = 3'd5;
   localparam logic [PC_W-1:0] STEP_MERGE  = 3'd6;

   typedef struct packed {
      logic [1:0]      wr_sel;
      logic [2:0]      ptr_op;
      logic            carry_load;
      logic [1:0]      emit;
      logic [2:0]      cond;
      logic            loop;
      logic [PC_W-1:0] target;
      logic            idle;
   } ctl_word_type;

   typedef struct packed {
      logic load_done;
      logic a_last;
      logic b_last;
      logic pass_more;
      logic merge_last;
   } status_type;

   function automatic ctl_word_type microcode(input logic [PC_W-1:0] step);
      ctl_word_type w;
      w = '0;
      case (step)
         STEP_LOAD: begin
            w.wr_sel = WR_LOAD;
            w.ptr_op = PTR_CLEAR;
            w.idle   = 1'b1;
            w.cond   = COND_LOAD_DONE;
            w.target = STEP_PASS;
            w.loop   = 1'b1;
         end
         STEP_PASS: begin
            w.carry_load = 1'b1;
            w.ptr_op     = PTR_WRAP_BOTH;
            w.cond       = COND_NEVER;
         end
         STEP_CMP: begin
            w.wr_sel = WR_CMP;
            w.ptr_op = PTR_WRAP_BOTH;
            w.cond   = COND_A_LAST;
            w.target = STEP_TAIL;
            w.loop   = 1'b1;
         end
         STEP_TAIL: begin
            w.wr_sel = WR_TAIL;
            w.ptr_op = PTR_HOLD;
            w.cond   = COND_PASS_MORE;
            w.target = STEP_PASS;
         end
         STEP_EMIT_A: begin
            w.emit   = EMIT_A;
            w.ptr_op = PTR_WRAP_A;
            w.cond   = COND_A_LAST;
            w.target = STEP_EMIT_B;
            w.loop   = 1'b1;
         end
         STEP_EMIT_B: begin
            w.emit   = EMIT_B;
            w.ptr_op = PTR_WRAP_B;
            w.cond   = COND_B_LAST;
            w.target = STEP_MERGE;
            w.loop   = 1'b1;
         end
         STEP_MERGE: begin
            w.emit   = EMIT_MERGE;
            w.ptr_op = PTR_MERGE;
            w.cond   = COND_MERGE_LAST;
            w.target = STEP_LOAD;
            w.loop   = 1'b1;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_LOAD;
         end
      endcase
      return w;
   endfunction

endpackage

// File: hdl/sort_two_lists_and_merge.sv
// Top level: command handshake, sequencer, datapath and result register.
//
//   channel   ports                                   handshake
//   request   start, busy, req_value                  word taken when start && !busy
//   result    rsp_valid, rsp_run_kind, rsp_element,   one-cycle strobe, no back-pressure
//             rsp_swaps_a, rsp_swaps_b, rsp_last
//
// Each of the first 2*LIST_LEN-1 words of a job is taken with busy low. The final
// word raises busy while both lists sort side by side, then through the result
// run; each result is registered and appears in the cycle after its emit step.
// Synchronous reset returns the sequencer to loading with an empty job.
module sort_two_lists_and_merge #(
   parameter int LIST_LEN = srtmrg_pkg::LIST_LEN_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [srtmrg_pkg::DATA_W-1:0]  req_value,
   output logic                                  rsp_valid,
   output logic [srtmrg_pkg::KIND_W-1:0]         rsp_run_kind,
   output logic signed [srtmrg_pkg::DATA_W-1:0]  rsp_element,
   output logic [srtmrg_pkg::SWAP_W-1:0]         rsp_swaps_a,
   output logic [srtmrg_pkg::SWAP_W-1:0]         rsp_swaps_b,
   output logic                                  rsp_last
);
   import srtmrg_pkg::*;

   ctl_word_type      ctl;
   status_type        status;
   logic              accept;
   logic [DATA_W-1:0] emit_element;
   logic              emit_last;
   logic [SWAP_W-1:0] swaps_a, swaps_b;
   logic [KIND_W-1:0] kind;

   logic              rsp_valid_ff;
   logic [KIND_W-1:0] rsp_run_kind_ff;
   logic [DATA_W-1:0] rsp_element_ff;
   logic [SWAP_W-1:0] rsp_swaps_a_ff, rsp_swaps_b_ff;
   logic              rsp_last_ff;

   assign busy   = !ctl.idle;
   assign accept = start && !busy;

   srtmrg_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   srtmrg_dp #(.LIST_LEN(LIST_LEN)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .load_en      (accept),
      .load_value   (req_value),
      .status       (status),
      .emit_element (emit_element),
      .emit_last    (emit_last),
      .swaps_a      (swaps_a),
      .swaps_b      (swaps_b)
   );

   always_comb begin
      case (ctl.emit)
         EMIT_A:     kind = KIND_A;
         EMIT_B:     kind = KIND_B;
         EMIT_MERGE: kind = KIND_MERGE;
         default:    kind = KIND_A;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (ctl.emit != EMIT_NONE);
      end
   end

   always_ff @(posedge clock) begin
      rsp_run_kind_ff <= kind;
      rsp_element_ff  <= emit_element;
      rsp_swaps_a_ff  <= swaps_a;
      rsp_swaps_b_ff  <= swaps_b;
      rsp_last_ff     <= emit_last;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_run_kind = rsp_run_kind_ff;
   assign rsp_element  = rsp_element_ff;
   assign rsp_swaps_a  = rsp_swaps_a_ff;
   assign rsp_swaps_b  = rsp_swaps_b_ff;
   assign rsp_last     = rsp_last_ff && rsp_valid_ff;
endmodule

// File: hdl/srtmrg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srtmrg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/srtmrg_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module srtmrg_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  srtmrg_pkg::status_type    status,
   output srtmrg_pkg::ctl_word_type  ctl
);
   import srtmrg_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            take;

   assign ctl = microcode(pc_ff);

   always_comb begin
      case (ctl.cond)
         COND_NEVER:      take = 1'b0;
         COND_ALWAYS:     take = 1'b1;
         COND_LOAD_DONE:  take = status.load_done;
         COND_A_LAST:     take = status.a_last;
         COND_B_LAST:     take = status.b_last;
         COND_PASS_MORE:  take = status.pass_more;
         COND_MERGE_LAST: take = status.merge_last;
         default:         take = 1'b1;
      endcase
   end

   always_comb begin
      if (take) begin
         pc_in = ctl.target;
      end else if (ctl.loop) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end
endmodule

// File: hdl/srtmrg_dp.sv
// Datapath: list RAMs, pointers, bubble-pass carry, swap counters and merge select.
module srtmrg_dp #(
   parameter int LIST_LEN = srtmrg_pkg::LIST_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  srtmrg_pkg::ctl_word_type          ctl,
   input  logic                              load_en,
   input  logic [srtmrg_pkg::DATA_W-1:0]     load_value,
   output srtmrg_pkg::status_type            status,
   output logic [srtmrg_pkg::DATA_W-1:0]     emit_element,
   output logic                              emit_last,
   output logic [srtmrg_pkg::SWAP_W-1:0]     swaps_a,
   output logic [srtmrg_pkg::SWAP_W-1:0]     swaps_b
);
   import srtmrg_pkg::*;

   localparam int AW = (LIST_LEN > 1) ? $clog2(LIST_LEN) : 1;
   localparam int PW = $clog2(LIST_LEN + 1);
   localparam int LW = $clog2(2 * LIST_LEN);
   localparam int XW = (LIST_LEN > 2) ? $clog2(LIST_LEN - 1) : 1;

   logic [LW-1:0]     load_cnt_ff, load_cnt_in;
   logic [PW-1:0]     ia_ff, ia_in, ib_ff, ib_in;
   logic [XW-1:0]     pass_ff, pass_in;
   logic [SWAP_W-1:0] swaps_a_ff, swaps_a_in, swaps_b_ff, swaps_b_in;
   logic [DATA_W-1:0] carry_a_ff, carry_a_in, carry_b_ff, carry_b_in;

   logic [DATA_W-1:0] rd_a, rd_b;
   logic [AW-1:0]     rd_addr_a, rd_addr_b;
   logic              wa_en, wb_en;
   logic [AW-1:0]     wa_addr, wb_addr;
   logic [DATA_W-1:0] wa_data, wb_data;

   logic              load_final, load_to_b;
   logic [LW-1:0]     load_b_idx;
   logic [PW-1:0]     ia_wrap, ib_wrap, ia_dec;
   logic              gt_a, gt_b, a_done, b_done, take_a, merge_last;
   logic [PW:0]       merge_sum;

   srtmrg_ram #(.WIDTH(DATA_W), .DEPTH(LIST_LEN)) u_ram_a (
      .clock   (clock),
      .wr_en   (wa_en),
      .wr_addr (wa_addr),
      .wr_data (wa_data),
      .rd_addr (rd_addr_a),
      .rd_data (rd_a)
   );

   srtmrg_ram #(.WIDTH(DATA_W), .DEPTH(LIST_LEN)) u_ram_b (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (wb_addr),
      .wr_data (wb_data),
      .rd_addr (rd_addr_b),
      .rd_data (rd_b)
   );

   assign load_final = (load_cnt_ff == LW'(2 * LIST_LEN - 1));
   assign load_to_b  = (load_cnt_ff >= LW'(LIST_LEN));
   assign load_b_idx = load_cnt_ff - LW'(LIST_LEN);

   assign ia_wrap = (ia_ff == PW'(LIST_LEN - 1)) ? '0 : ia_ff + PW'(1);
   assign ib_wrap = (ib_ff == PW'(LIST_LEN - 1)) ? '0 : ib_ff + PW'(1);
   assign ia_dec  = ia_ff - PW'(1);

   // carry holds the larger value bubbling right through the pass
   assign gt_a = $signed(carry_a_ff) > $signed(rd_a);
   assign gt_b = $signed(carry_b_ff) > $signed(rd_b);

   // merge: tie takes from A
   assign a_done     = (ia_ff == PW'(LIST_LEN));
   assign b_done     = (ib_ff == PW'(LIST_LEN));
   assign take_a     = b_done || (!a_done && !($signed(rd_a) > $signed(rd_b)));
   assign merge_sum  = {1'b0, ia_ff} + {1'b0, ib_ff};
   assign merge_last = (merge_sum == (PW + 1)'(2 * LIST_LEN - 1));

   always_comb begin
      wa_en   = 1'b0;
      wb_en   = 1'b0;
      wa_addr = ia_dec[AW-1:0];
      wb_addr = ia_dec[AW-1:0];
      wa_data = gt_a ? rd_a : carry_a_ff;
      wb_data = gt_b ? rd_b : carry_b_ff;
      case (ctl.wr_sel)
         WR_LOAD: begin
            wa_en   = load_en && !load_to_b;
            wb_en   = load_en && load_to_b;
            wa_addr = load_cnt_ff[AW-1:0];
            wb_addr = load_b_idx[AW-1:0];
            wa_data = load_value;
            wb_data = load_value;
         end
         WR_CMP: begin
            wa_en = 1'b1;
            wb_en = 1'b1;
         end
         WR_TAIL: begin
            wa_en   = 1'b1;
            wb_en   = 1'b1;
            wa_addr = AW'(LIST_LEN - 1);
            wb_addr = AW'(LIST_LEN - 1);
            wa_data = carry_a_ff;
            wb_data = carry_b_ff;
         end
         default: begin
            wa_en = 1'b0;
            wb_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (ctl.ptr_op)
         PTR_CLEAR: begin
            ia_in = '0;
            ib_in = '0;
         end
         PTR_WRAP_BOTH: begin
            ia_in = ia_wrap;
            ib_in = ib_wrap;
         end
         PTR_WRAP_A: begin
            ia_in = ia_wrap;
            ib_in = '0;
         end
         PTR_WRAP_B: begin
            ia_in = '0;
            ib_in = ib_wrap;
         end
         PTR_MERGE: begin
            ia_in = take_a ? ia_ff + PW'(1) : ia_ff;
            ib_in = take_a ? ib_ff : ib_ff + PW'(1);
         end
         default: begin
            ia_in = ia_ff;
            ib_in = ib_ff;
         end
      endcase
   end

   // address the next pointer so read data lines up with the pointer register
   assign rd_addr_a = (ia_in < PW'(LIST_LEN)) ? ia_in[AW-1:0] : '0;
   assign rd_addr_b = (ib_in < PW'(LIST_LEN)) ? ib_in[AW-1:0] : '0;

   always_comb begin
      load_cnt_in = load_cnt_ff;
      if (ctl.wr_sel == WR_LOAD && load_en) begin
         load_cnt_in = load_final ? '0 : load_cnt_ff + LW'(1);
      end
   end

   always_comb begin
      pass_in    = pass_ff;
      swaps_a_in = swaps_a_ff;
      swaps_b_in = swaps_b_ff;
      carry_a_in = carry_a_ff;
      carry_b_in = carry_b_ff;
      if (status.load_done) begin
         swaps_a_in = '0;
         swaps_b_in = '0;
      end
      if (ctl.carry_load) begin
         carry_a_in = rd_a;
         carry_b_in = rd_b;
      end
      if (ctl.wr_sel == WR_CMP) begin
         carry_a_in = gt_a ? carry_a_ff : rd_a;
         carry_b_in = gt_b ? carry_b_ff : rd_b;
         if (gt_a) begin
            swaps_a_in = swaps_a_ff + SWAP_W'(1);
         end
         if (gt_b) begin
            swaps_b_in = swaps_b_ff + SWAP_W'(1);
         end
      end
      if (ctl.wr_sel == WR_TAIL) begin
         pass_in = status.pass_more ? pass_ff + XW'(1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         ia_ff       <= '0;
         ib_ff       <= '0;
         pass_ff     <= '0;
         swaps_a_ff  <= '0;
         swaps_b_ff  <= '0;
      end else begin
         load_cnt_ff <= load_cnt_in;
         ia_ff       <= ia_in;
         ib_ff       <= ib_in;
         pass_ff     <= pass_in;
         swaps_a_ff  <= swaps_a_in;
         swaps_b_ff  <= swaps_b_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_a_ff <= carry_a_in;
      carry_b_ff <= carry_b_in;
   end

   assign status.load_done  = (ctl.wr_sel == WR_LOAD) && load_en && load_final;
   assign status.a_last     = (ia_ff == PW'(LIST_LEN - 1));
   assign status.b_last     = (ib_ff == PW'(LIST_LEN - 1));
   assign status.pass_more  = (pass_ff != XW'(LIST_LEN - 2));
   assign status.merge_last = merge_last;

   always_comb begin
      case (ctl.emit)
         EMIT_A:     emit_element = rd_a;
         EMIT_B:     emit_element = rd_b;
         EMIT_MERGE: emit_element = take_a ? rd_a : rd_b;
         default:    emit_element = rd_a;
      endcase
   end

   assign emit_last = (ctl.emit == EMIT_MERGE) && merge_last;
   assign swaps_a   = swaps_a_ff;
   assign swaps_b   = swaps_b_ff;
endmodule

// File: hdl/srtmrg_chk.sv
// Port-level checker for the sort-and-merge block, bound to the top level.
module srtmrg_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [srtmrg_pkg::KIND_W-1:0] rsp_run_kind,
   input logic                          rsp_last
);
   import srtmrg_pkg::*;

   // only the final merged word may coincide with the block going idle
   a_busy_during_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("result word outside a busy run");

   a_last_is_merge: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid && rsp_run_kind == KIND_MERGE)
      else $error("last flag on a word that is not merged");

   a_b_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_kind == KIND_B |=> rsp_valid)
      else $error("gap after a list B word");

   a_quiet_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_last |=> !rsp_valid)
      else $error("result word right after the last one");
endmodule

bind sort_two_lists_and_merge srtmrg_chk u_chk (.*);
